@@ src/sts_pkg.sv @@
package sts_pkg;

  // Keyword table: text is right-justified, so byte p of a word of length L
  // sits at bits [(L-1-p)*8 +: 8].
  localparam int KW_TABLE  = 47;
  localparam int KW_CHARS  = 11;

  localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_TABLE] = '{
    "AND", "AS", "ASC", "BEGIN", "BETWEEN", "BY", "COMMIT", "CREATE",
    "DEFAULT", "DELETE", "DESC", "DROP", "FROM", "GROUP", "HAVING", "IN",
    "INDEX", "INNER", "INSERT", "INTO", "IS", "JOIN", "KEY", "LEFT", "LIKE",
    "LIMIT", "NOT", "NULL", "OFFSET", "ON", "OR", "ORDER", "OUTER", "PRIMARY",
    "RELEASE", "RIGHT", "ROLLBACK", "SAVEPOINT", "SELECT", "SET", "TABLE",
    "TO", "TRANSACTION", "UNIQUE", "UPDATE", "VALUES", "WHERE"
  };

  localparam logic [3:0] KW_LEN [KW_TABLE] = '{
    4'd3, 4'd2, 4'd3, 4'd5, 4'd7, 4'd2, 4'd6, 4'd6,
    4'd7, 4'd6, 4'd4, 4'd4, 4'd4, 4'd5, 4'd6, 4'd2,
    4'd5, 4'd5, 4'd6, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd3, 4'd4, 4'd6, 4'd2, 4'd2, 4'd5, 4'd5, 4'd7,
    4'd7, 4'd5, 4'd8, 4'd9, 4'd6, 4'd3, 4'd5,
    4'd2, 4'd11, 4'd6, 4'd6, 4'd6, 4'd5
  };

  localparam logic [3:0] IDLEN_MAX = 4'd15;

  // Token kinds beyond the keywords
  localparam logic [6:0] K_IDENT   = 7'd47;
  localparam logic [6:0] K_INT     = 7'd48;
  localparam logic [6:0] K_FLOAT   = 7'd49;
  localparam logic [6:0] K_STRING  = 7'd50;
  localparam logic [6:0] K_LPAREN  = 7'd51;
  localparam logic [6:0] K_RPAREN  = 7'd52;
  localparam logic [6:0] K_COMMA   = 7'd53;
  localparam logic [6:0] K_DOT     = 7'd54;
  localparam logic [6:0] K_SEMI    = 7'd55;
  localparam logic [6:0] K_STAR    = 7'd56;
  localparam logic [6:0] K_PLUS    = 7'd57;
  localparam logic [6:0] K_MINUS   = 7'd58;
  localparam logic [6:0] K_SLASH   = 7'd59;
  localparam logic [6:0] K_PERCENT = 7'd60;
  localparam logic [6:0] K_EQ      = 7'd61;
  localparam logic [6:0] K_NE      = 7'd62;
  localparam logic [6:0] K_LT      = 7'd63;
  localparam logic [6:0] K_LE      = 7'd64;
  localparam logic [6:0] K_GT      = 7'd65;
  localparam logic [6:0] K_GE      = 7'd66;
  localparam logic [6:0] K_PARAM   = 7'd67;
  localparam logic [6:0] K_ERROR   = 7'd68;
  localparam logic [6:0] K_EOF     = 7'd69;

  // Error codes
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_UNTERM = 2'd1;
  localparam logic [1:0] E_BANG   = 2'd2;
  localparam logic [1:0] E_CHAR   = 2'd3;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int MAX_RES = 3;

  typedef enum logic [16:0] {
    M_IDLE  = 17'b00000000000000001,
    M_LINEC = 17'b00000000000000010,
    M_BLOCK = 17'b00000000000000100,
    M_BSTAR = 17'b00000000000001000,
    M_MINUS = 17'b00000000000010000,
    M_SLASH = 17'b00000000000100000,
    M_LT    = 17'b00000000001000000,
    M_GT    = 17'b00000000010000000,
    M_BANG  = 17'b00000000100000000,
    M_IDENT = 17'b00000001000000000,
    M_INT   = 17'b00000010000000000,
    M_DOT   = 17'b00000100000000000,
    M_FRAC  = 17'b00001000000000000,
    M_EXP   = 17'b00010000000000000,
    M_EXPD  = 17'b00100000000000000,
    M_STR   = 17'b01000000000000000,
    M_ESC   = 17'b10000000000000000
  } mode_e;

  typedef struct packed {
    logic [6:0]  kind;
    logic [1:0]  err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } tok_t;

  // True when keyword i still matches with byte up at place p
  function automatic logic kw_match(int i, logic [3:0] p, logic [7:0] up);
    logic [7:0] ch;
    int         sh;
    begin
      kw_match = 1'b0;
      if (i < KW_TABLE) begin
        if (p < KW_LEN[i]) begin
          sh = (int'(KW_LEN[i]) - 1 - int'(p)) * 8;
          ch = KW_TEXT[i][sh +: 8];
          kw_match = (ch == up);
        end
      end
    end
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage

@@ src/sts_char_if.sv @@
interface sts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, in_char, end_of_text, input ready);
  modport sink (input valid, in_char, end_of_text, output ready);
endinterface

@@ src/sts_tok_if.sv @@
interface sts_tok_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [1:0]  error_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic        last_token;

  modport source (output valid, token_kind, error_kind, token_start, token_length,
                  token_line, last_token, input ready);
  modport sink (input valid, token_kind, error_kind, token_start, token_length,
                token_line, last_token, output ready);
endinterface

@@ src/sql_token_scanner.sv @@
// Channel  | Dir | Payload                                        | Transaction
// char_i   | in  | in_char, end_of_text                           | one source byte
// tok_o    | out | token_kind, error_kind, token_start/length/line | one token
//
// A byte is scanned in the cycle it is taken; its tokens (up to three) go into
// a four-entry output queue and leave one per cycle while tok_o is ready.
// One byte per cycle while the queue holds at most one token; the queue drain
// rate (one token a cycle) sets the pace when bytes close several tokens.
// Reset clears the scanner to line 1, offset 0; no clearing pass.
// A stalled tok_o holds char_i off as soon as two tokens wait in the queue.
module sql_token_scanner
  import sts_pkg::*;
#(
  parameter int POS_WIDTH     = 16,
  parameter int KEYWORD_COUNT = 47
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sts_char_if.sink   char_i,
  sts_tok_if.source  tok_o
);

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  function automatic logic [15:0] sat16(logic [POS_WIDTH-1:0] v);
    logic [32:0] ext;
    begin
      ext = 33'(v);
      sat16 = (ext > 33'd65535) ? 16'hFFFF : ext[15:0];
    end
  endfunction

  function automatic logic [POS_WIDTH-1:0] pdiff(logic [POS_WIDTH-1:0] a,
                                                 logic [POS_WIDTH-1:0] b);
    return (a >= b) ? (a - b) : '0;
  endfunction

  // Scanner state
  logic [POS_WIDTH-1:0]     pos_q, pos_d, line_q, line_d, start_q, start_d;
  logic [POS_WIDTH-1:0]     mark_q, mark_d;
  mode_e                    mode_q, mode_d;
  logic [KEYWORD_COUNT-1:0] cand_q, cand_d;
  logic [7:0]               quote_q, quote_d;
  logic [3:0]               idlen_q, idlen_d;

  // Output queue
  tok_t                     queue_q [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]        cnt_q;

  tok_t                     res [MAX_RES];
  logic [1:0]               res_cnt;
  logic                     accept, pop;

  assign char_i.ready = (cnt_q <= QCNT_W'(QDEPTH - MAX_RES));
  assign accept       = char_i.valid && char_i.ready;
  assign tok_o.valid  = (cnt_q != '0);
  assign pop          = tok_o.valid && tok_o.ready;

  assign tok_o.token_kind   = queue_q[rd_ptr_q].kind;
  assign tok_o.error_kind   = queue_q[rd_ptr_q].err;
  assign tok_o.token_start  = queue_q[rd_ptr_q].start;
  assign tok_o.token_length = queue_q[rd_ptr_q].len;
  assign tok_o.token_line   = queue_q[rd_ptr_q].line;
  assign tok_o.last_token   = queue_q[rd_ptr_q].last;

  // Scan one byte: next state and the tokens it closes
  always_comb begin
    logic [7:0]           c, up;
    logic [POS_WIDTH-1:0] cur, nxt, line_up;
    logic                 eot, do_flush, do_start;
    logic [6:0]           kw_kind;
    tok_t                 t;

    c        = char_i.in_char;
    eot      = char_i.end_of_text;
    cur      = pos_q;
    nxt      = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
    line_up  = (line_q == POS_MAX) ? line_q : line_q + POS_ONE;
    up       = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    do_flush = 1'b0;
    do_start = 1'b0;

    pos_d   = pos_q;
    line_d  = line_q;
    start_d = start_q;
    mark_d  = mark_q;
    mode_d  = mode_q;
    cand_d  = cand_q;
    quote_d = quote_q;
    idlen_d = idlen_q;
    res_cnt = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end

    // Keyword of the pending identifier, lowest table entry wins
    kw_kind = K_IDENT;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (cand_q[i] && (i < KW_TABLE)) begin
        if (KW_LEN[i] == idlen_q) kw_kind = 7'(i);
      end
    end

    t      = '0;
    t.line = sat16(line_q);

    if (eot) begin
      do_flush = 1'b1;
    end else begin
      pos_d = nxt;
      unique case (mode_q)
        M_LINEC: begin
          if (c == 8'h0A) begin
            line_d = line_up;
            mode_d = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (c == "*") mode_d = M_BSTAR;
          else if (c == 8'h0A) line_d = line_up;
        end
        M_BSTAR: begin
          if (c == "/") mode_d = M_IDLE;
          else if (c != "*") begin
            if (c == 8'h0A) line_d = line_up;
            mode_d = M_BLOCK;
          end
        end
        M_MINUS: begin
          if (c == "-") mode_d = M_LINEC;
          else do_start = 1'b1;
        end
        M_SLASH: begin
          if (c == "*") mode_d = M_BLOCK;
          else do_start = 1'b1;
        end
        M_LT, M_GT, M_BANG: begin
          if (c == "=" || (c == ">" && mode_q == M_LT)) begin
            t.kind  = (mode_q == M_GT) ? K_GE :
                      (mode_q == M_LT && c == "=") ? K_LE : K_NE;
            t.start = sat16(start_q);
            t.len   = sat16(pdiff(nxt, start_q));
            res[0]  = t;
            res_cnt = 2'd1;
            mode_d  = M_IDLE;
          end else begin
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            for (int i = 0; i < KEYWORD_COUNT; i++) begin
              cand_d[i] = cand_q[i] && kw_match(i, idlen_q, up);
            end
            if (idlen_q < IDLEN_MAX) idlen_d = idlen_q + 4'd1;
          end else begin
            do_start = 1'b1;
          end
        end
        M_INT: begin
          if (c == ".") begin
            mark_d = cur;
            mode_d = M_DOT;
          end else if (c == "e" || c == "E") mode_d = M_EXP;
          else if (!is_digit(c)) do_start = 1'b1;
        end
        M_DOT: begin
          if (is_digit(c)) mode_d = M_FRAC;
          else do_start = 1'b1;
        end
        M_FRAC: begin
          if (c == "e" || c == "E") mode_d = M_EXP;
          else if (!is_digit(c)) do_start = 1'b1;
        end
        M_EXP: begin
          if (c == "+" || c == "-" || is_digit(c)) mode_d = M_EXPD;
          else do_start = 1'b1;
        end
        M_EXPD: begin
          if (!is_digit(c)) do_start = 1'b1;
        end
        M_STR: begin
          if (c == quote_q) begin
            t.kind  = K_STRING;
            t.start = sat16(start_q);
            t.len   = sat16(pdiff(nxt, start_q));
            res[0]  = t;
            res_cnt = 2'd1;
            mode_d  = M_IDLE;
          end else if (c == 8'h0A) line_d = line_up;
          else if (c == 8'h5C) mode_d = M_ESC;
        end
        M_ESC: mode_d = M_STR;
        M_IDLE: begin
          do_start = 1'b1;
        end
        default: mode_d = M_IDLE;
      endcase
      do_flush = do_start;
    end

    // Close the pending token at the current offset
    if (do_flush) begin
      t.start = sat16(start_q);
      t.len   = sat16(pdiff(cur, start_q));
      t.err   = E_NONE;
      t.kind  = K_EOF;
      unique case (mode_q)
        M_MINUS: t.kind = K_MINUS;
        M_SLASH: t.kind = K_SLASH;
        M_LT:    t.kind = K_LT;
        M_GT:    t.kind = K_GT;
        M_BANG: begin
          t.kind = K_ERROR;
          t.err  = E_BANG;
        end
        M_IDENT: t.kind = kw_kind;
        M_INT:   t.kind = K_INT;
        M_DOT: begin
          t.kind = K_INT;
          t.len  = sat16(pdiff(mark_q, start_q));
        end
        M_FRAC, M_EXP, M_EXPD: t.kind = K_FLOAT;
        M_STR, M_ESC: begin
          t.kind = K_ERROR;
          t.err  = E_UNTERM;
        end
        default: t.kind = K_EOF;
      endcase
      if (t.kind != K_EOF) begin
        res[0]  = t;
        res_cnt = 2'd1;
      end
      if (mode_q == M_DOT) begin
        t.kind  = K_DOT;
        t.err   = E_NONE;
        t.start = sat16(mark_q);
        t.len   = sat16(pdiff(cur, mark_q));
        res[1]  = t;
        res_cnt = 2'd2;
      end
      mode_d = M_IDLE;
    end

    // Handle the byte afresh from idle
    if (do_start) begin
      start_d = cur;
      mode_d  = M_IDLE;
      t.start = sat16(cur);
      t.len   = sat16(pdiff(nxt, cur));
      t.err   = E_NONE;
      t.kind  = K_EOF;
      unique case (c)
        " ", 8'h0D, 8'h09: t.kind = K_EOF;
        8'h0A: line_d = line_up;
        "-": mode_d = M_MINUS;
        "/": mode_d = M_SLASH;
        "<": mode_d = M_LT;
        ">": mode_d = M_GT;
        "!": mode_d = M_BANG;
        "(": t.kind = K_LPAREN;
        ")": t.kind = K_RPAREN;
        ",": t.kind = K_COMMA;
        ".": t.kind = K_DOT;
        ";": t.kind = K_SEMI;
        "*": t.kind = K_STAR;
        "+": t.kind = K_PLUS;
        "%": t.kind = K_PERCENT;
        "=": t.kind = K_EQ;
        "?": t.kind = K_PARAM;
        8'h27, 8'h22: begin
          quote_d = c;
          mode_d  = M_STR;
        end
        default: begin
          if (is_alpha(c) || c == "_") begin
            mode_d  = M_IDENT;
            idlen_d = 4'd1;
            for (int i = 0; i < KEYWORD_COUNT; i++) begin
              cand_d[i] = kw_match(i, 4'd0, up);
            end
          end else if (is_digit(c)) begin
            mode_d = M_INT;
          end else begin
            t.kind = K_ERROR;
            t.err  = E_CHAR;
          end
        end
      endcase
      if (t.kind != K_EOF) begin
        res[res_cnt] = t;
        res_cnt      = res_cnt + 2'd1;
      end
    end

    // End of text: EOF token, then back to reset values
    if (eot) begin
      t.kind       = K_EOF;
      t.err        = E_NONE;
      t.start      = sat16(cur);
      t.len        = '0;
      res[res_cnt] = t;
      res_cnt      = res_cnt + 2'd1;
      pos_d   = '0;
      line_d  = POS_ONE;
      start_d = '0;
      mode_d  = M_IDLE;
      cand_d  = '1;
      quote_d = '0;
      mark_d  = '0;
      idlen_d = '0;
    end

    // Flag the final token of this byte
    for (int k = 0; k < MAX_RES; k++) begin
      res[k].last = (2'(k + 1) == res_cnt);
    end
  end

  // Advance scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      line_q  <= POS_ONE;
      start_q <= '0;
      mark_q  <= '0;
      mode_q  <= M_IDLE;
      cand_q  <= '1;
      quote_q <= '0;
      idlen_q <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      line_q  <= line_d;
      start_q <= start_d;
      mark_q  <= mark_d;
      mode_q  <= mode_d;
      cand_q  <= cand_d;
      quote_q <= quote_d;
      idlen_q <= idlen_d;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) wr_ptr_q <= wr_ptr_q + QPTR_W'(res_cnt);
      if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + (accept ? QCNT_W'(res_cnt) : '0) - (pop ? QCNT_W'(1) : '0);
    end
  end

  // Write the new tokens into the queue
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < res_cnt) queue_q[wr_ptr_q + QPTR_W'(k)] <= res[k];
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("output queue overfilled");

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("scan mode not one-hot");

  a_eot_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && char_i.end_of_text |=> (pos_q == '0) && (line_q == POS_ONE)
                                      && (mode_q == M_IDLE))
    else $error("scanner did not restart after end of text");

  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && char_i.end_of_text |-> res_cnt != 2'd0)
    else $error("end of text produced no token");
`endif

endmodule
